// ===== rtl/sli_pkg.sv =====
// Shared types and constants for the sorted list insert/delete block.
package sli_pkg;

    // Default number of list entries
    localparam int CAPACITY = 16;

    // Operation codes on the op field
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } sli_status_t;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } sli_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;   // capture the incoming transfer
        logic exec;      // update the cell row and load the result register
    } sli_cmd_t;

endpackage

// ===== rtl/sorted_list_insert_delete.sv =====
// Sorted list insert/delete: ascending signed list in a row of compare-and-shift cells.
// Each accepted transfer (op 0 insert, op 1 delete first equal entry) yields one result
// with status, entry count after the operation, and smallest entry with an empty flag.
// Each item is first captured into the input register, then goes through an execute
// step in which every cell compares against the value and shifts in a single step. A new
// transfer is taken while the previous result still waits in the output register; the
// execute step waits only when that register is full and not being drained. An insert
// into a full list is dropped with status full. No clearing pass is needed after reset.
module sorted_list_insert_delete #(
    parameter int CAPACITY = sli_pkg::CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic signed [31:0]            s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [$clog2(CAPACITY+1)-1:0] m_entry_count,
    output logic signed [31:0]            m_smallest_value,
    output logic                          m_list_empty
);

    sli_pkg::sli_cmd_t cmd;

    // Control
    sli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Cell row and result register
    sli_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_op             (s_op),
        .s_value          (s_value),
        .m_status         (m_status),
        .m_entry_count    (m_entry_count),
        .m_smallest_value (m_smallest_value),
        .m_list_empty     (m_list_empty)
    );

endmodule

// ===== rtl/sli_ctrl.sv =====
// Controller state machine: input capture, execute step and result register valid.
module sli_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output sli_pkg::sli_cmd_t cmd
);

    sli_pkg::sli_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;

    // State and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sli_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        s_ready     = 1'b0;
        unique case (state_reg)
            sli_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = sli_pkg::S_EXEC;
                end
            end
            sli_pkg::S_EXEC: begin
                // wait until the result register is free or being emptied
                if (!out_valid_reg || m_ready) begin
                    cmd.exec   = 1'b1;
                    state_next = sli_pkg::S_IDLE;
                end
            end
            default: state_next = sli_pkg::S_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready)
            out_valid_next = 1'b0;
        if (cmd.exec)
            out_valid_next = 1'b1;
    end

    assign m_valid = out_valid_reg;

    // An accepted transfer always leads to the execute step
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == sli_pkg::S_EXEC))
        else $error("accepted transfer did not enter execute");

    // Executing always presents a result next cycle
    a_exec_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid)
        else $error("execute step produced no result");

    // Never execute while a result is stalled on the output
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while stalled");

endmodule

// ===== rtl/sli_datapath.sv =====
// Datapath: input register, row of compare-and-shift cells, entry count, result register.
module sli_datapath #(
    parameter int CAPACITY = sli_pkg::CAPACITY
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sli_pkg::sli_cmd_t                 cmd,
    input  logic                              s_op,
    input  logic signed [31:0]                s_value,
    output logic [1:0]                        m_status,
    output logic [$clog2(CAPACITY+1)-1:0]     m_entry_count,
    output logic signed [31:0]                m_smallest_value,
    output logic                              m_list_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                op_reg;
    logic signed [31:0]  value_reg;
    logic signed [31:0]  entries_reg  [CAPACITY];
    logic signed [31:0]  entries_next [CAPACITY];
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;
    logic                full, found, insert_en, delete_en;
    sli_pkg::sli_status_t status_next, status_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic signed [31:0]  out_smallest_reg;
    logic                out_empty_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= s_op;
            value_reg <= s_value;
        end
    end

    // Per-cell compare against the held value; only cells below the count take part
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
        logic cell_valid;
        assign cell_valid = CNT_W'(i) < count_reg;
        assign lt[i] = cell_valid && (entries_reg[i] < value_reg);
        assign eq[i] = cell_valid && (entries_reg[i] == value_reg);
    end

    // Operation decode
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign found     = |eq;
    assign insert_en = cmd.exec && (op_reg == sli_pkg::OP_INSERT) && !full;
    assign delete_en = cmd.exec && (op_reg == sli_pkg::OP_DELETE) && found;

    // Cell next values: list is sorted, so lt is a run of ones from cell 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        always_comb begin
            entries_next[i] = entries_reg[i];
            if (insert_en && !lt[i]) begin
                if (i == 0) begin
                    entries_next[i] = value_reg;
                end else if (lt[(i == 0) ? 0 : i - 1]) begin
                    entries_next[i] = value_reg;
                end else begin
                    entries_next[i] = entries_reg[(i == 0) ? 0 : i - 1];
                end
            end else if (delete_en && !lt[i] && (i < CAPACITY - 1)) begin
                entries_next[i] = entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.exec)
                entries_reg[i] <= entries_next[i];
        end
    end

    // Count update and status
    always_comb begin
        count_next = count_reg;
        if (op_reg == sli_pkg::OP_INSERT) begin
            status_next = full ? sli_pkg::ST_FULL : sli_pkg::ST_INSERTED;
        end else begin
            status_next = found ? sli_pkg::ST_REMOVED : sli_pkg::ST_NOT_FOUND;
        end
        if (insert_en)
            count_next = count_reg + 1'b1;
        else if (delete_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg       <= status_next;
            out_count_reg    <= count_next;
            out_smallest_reg <= (count_next != '0) ? entries_next[0] : 32'sd0;
            out_empty_reg    <= (count_next == '0);
        end
    end

    assign m_status         = status_reg;
    assign m_entry_count    = out_count_reg;
    assign m_smallest_value = out_smallest_reg;
    assign m_list_empty     = out_empty_reg;

    // Count stays within the store
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A successful insert grows the list by one
    a_insert_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        insert_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the list");

    // Empty flag agrees with the reported count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> (m_list_empty == (m_entry_count == '0)))
        else $error("empty flag disagrees with count");

endmodule
